// ----- src/rmpt_pkg.sv -----
// ----------------------------------------------------------------------------
// rmpt_pkg
// Shared widths, codes, entry layout and helpers for the rate-monotonic
// priority table.
// ----------------------------------------------------------------------------
package rmpt_pkg;

  localparam int TABLE_DEPTH_DEF = 16;

  localparam int CMD_W   = 2;
  localparam int TASK_W  = 22;
  localparam int SEC_W   = 32;
  localparam int NS_W    = 30;
  localparam int STAT_W  = 2;
  localparam int LEVEL_W = 7;

  localparam logic [LEVEL_W-1:0] PRIO_LOW  = LEVEL_W'(1);
  localparam logic [LEVEL_W-1:0] PRIO_HIGH = LEVEL_W'(99);

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [TASK_W-1:0]  task_id;
    logic [SEC_W-1:0]   seconds;
    logic [NS_W-1:0]    nanos;
    logic [LEVEL_W-1:0] level;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // floor of the mean of two priorities
  function automatic logic [LEVEL_W-1:0] mid_level(input logic [LEVEL_W-1:0] a,
                                                   input logic [LEVEL_W-1:0] b);
    logic [LEVEL_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[LEVEL_W:1];
  endfunction

endpackage

// ----- src/rmpt_ram.sv -----
// ----------------------------------------------------------------------------
// rmpt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rmpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/rate_monotonic_priority_table.sv -----
// ----------------------------------------------------------------------------
// rate_monotonic_priority_table
// Period-ordered task table with rate-monotonic priority assignment.
// ----------------------------------------------------------------------------
// Commands are taken when start is high and busy is low; each command gives
// exactly one result beat on done, which the receiver must take in that
// cycle. Entries live packed, longest period first, in one synchronous RAM
// with one read and one write port, so every entry visited costs a read then
// a compare or a write. A full table or the unused code gives its result beat
// straight from the idle state, with no entry visited. A search scans until
// it finds the task or runs out of entries; a remove scans for the task, then
// moves each later entry down one place; an insert scans for its place, then
// moves each later entry up one place and writes the new entry there. Scanned
// and moved entries together never exceed the table depth.
// No clearing pass is needed after reset: the entry count alone marks live
// entries.
module rate_monotonic_priority_table #(
  parameter int TABLE_DEPTH = rmpt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [rmpt_pkg::CMD_W-1:0]   command,
  input  logic [rmpt_pkg::TASK_W-1:0]  task_id,
  input  logic [rmpt_pkg::SEC_W-1:0]   period_seconds,
  input  logic [rmpt_pkg::NS_W-1:0]    period_nanoseconds,
  output logic                         done,
  output logic [rmpt_pkg::STAT_W-1:0]  status,
  output logic [rmpt_pkg::LEVEL_W-1:0] priority_res
);
  import rmpt_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int OW = $clog2(TABLE_DEPTH + 1);
  localparam logic [OW-1:0] FULL_COUNT = OW'(TABLE_DEPTH);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD   = 6'b000010,
    S_CMP  = 6'b000100,
    S_SRD  = 6'b001000,
    S_SWR  = 6'b010000,
    S_INS  = 6'b100000
  } state_t;

  state_t             state;
  logic [OW-1:0]      occupancy;
  logic [OW-1:0]      idx;
  logic [OW-1:0]      pos;
  logic [OW-1:0]      j;
  logic [CMD_W-1:0]   cmd;
  logic [TASK_W-1:0]  id;
  logic [SEC_W-1:0]   sec;
  logic [NS_W-1:0]    ns;
  logic [LEVEL_W-1:0] prev_level;
  logic [LEVEL_W-1:0] prio;

  logic               we;
  logic [AW-1:0]      waddr;
  logic [AW-1:0]      raddr;
  logic [ENTRY_W-1:0] wdata;
  logic [ENTRY_W-1:0] rdata;
  entry_t             rd;
  entry_t             new_entry;
  logic [OW-1:0]      j_dn;
  logic [OW-1:0]      j_up;
  logic               is_ins;
  logic               key_eq;
  logic               key_gt;

  assign busy      = (state != S_IDLE);
  assign rd        = entry_t'(rdata);
  assign j_dn      = j - OW'(1);
  assign j_up      = j + OW'(1);
  assign is_ins    = (cmd == CMD_INSERT);
  assign key_eq    = ({sec, ns} == {rd.seconds, rd.nanos});
  assign key_gt    = ({sec, ns} > {rd.seconds, rd.nanos});
  assign new_entry = '{task_id: id, seconds: sec, nanos: ns, level: prio};

  // ram port control
  always_comb begin
    we    = (state == S_SWR) || (state == S_INS);
    waddr = (state == S_INS) ? pos[AW-1:0] : j[AW-1:0];
    wdata = (state == S_INS) ? new_entry : rdata;
    if (state == S_SRD) begin
      raddr = is_ins ? j_dn[AW-1:0] : j_up[AW-1:0];
    end else begin
      raddr = idx[AW-1:0];
    end
  end

  rmpt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occupancy <= '0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd        <= command;
            id         <= task_id;
            sec        <= period_seconds;
            ns         <= period_nanoseconds;
            idx        <= '0;
            prev_level <= PRIO_LOW;
            case (command)
              CMD_INSERT: begin
                if (occupancy == FULL_COUNT) begin
                  done         <= 1'b1;
                  status       <= ST_FULL;
                  priority_res <= '0;
                end else begin
                  state <= S_RD;
                end
              end
              CMD_SEARCH, CMD_REMOVE: begin
                state <= S_RD;
              end
              default: begin
                done         <= 1'b1;
                status       <= ST_OK;
                priority_res <= '0;
              end
            endcase
          end
        end
        S_RD: begin
          if (idx == occupancy) begin
            if (is_ins) begin
              prio  <= mid_level(prev_level, PRIO_HIGH);
              pos   <= occupancy;
              j     <= occupancy;
              state <= S_SRD;
            end else begin
              done         <= 1'b1;
              status       <= ST_NOT_FOUND;
              priority_res <= '0;
              state        <= S_IDLE;
            end
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (is_ins) begin
            if (key_eq) begin
              prio  <= rd.level;
              pos   <= idx + OW'(1);
              j     <= occupancy;
              state <= S_SRD;
            end else if (key_gt) begin
              prio  <= mid_level(prev_level, rd.level);
              pos   <= idx;
              j     <= occupancy;
              state <= S_SRD;
            end else begin
              prev_level <= rd.level;
              idx        <= idx + OW'(1);
              state      <= S_RD;
            end
          end else if (rd.task_id == id) begin
            if (cmd == CMD_SEARCH) begin
              done         <= 1'b1;
              status       <= ST_OK;
              priority_res <= rd.level;
              state        <= S_IDLE;
            end else begin
              j     <= idx;
              state <= S_SRD;
            end
          end else begin
            idx   <= idx + OW'(1);
            state <= S_RD;
          end
        end
        S_SRD: begin
          if (is_ins) begin
            state <= (j == pos) ? S_INS : S_SWR;
          end else if (j_up >= occupancy) begin
            occupancy    <= occupancy - OW'(1);
            done         <= 1'b1;
            status       <= ST_OK;
            priority_res <= '0;
            state        <= S_IDLE;
          end else begin
            state <= S_SWR;
          end
        end
        S_SWR: begin
          j     <= is_ins ? j_dn : j_up;
          state <= S_SRD;
        end
        S_INS: begin
          occupancy    <= occupancy + OW'(1);
          done         <= 1'b1;
          status       <= ST_OK;
          priority_res <= prio;
          state        <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= FULL_COUNT)
    else $error("entry count beyond table depth");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while command still running");

  a_occ_moves_with_beat: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && occupancy != $past(occupancy)) |-> done)
    else $error("entry count changed without a result beat");

  a_fail_zero_prio: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> priority_res == '0)
    else $error("failed command reports a priority");

  a_write_in_bounds: assert property (@(posedge clk) disable iff (rst)
    we |-> ({1'b0, waddr} < {1'b0, FULL_COUNT}))
    else $error("ram write outside the table");

endmodule
